FILE: rtl/abtf_pkg.sv
package abtf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int MEAS_BITS = SAMPLE_BITS + FRAC_BITS;

	localparam int ALPHA_BITS = 17;
	localparam int GAIN_BITS = 32;
	localparam int STEP_BITS = 25;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_INDEX_BITS = 2;

	localparam int GAIN_FRAC = 16;
	localparam int STEP_FRAC = 24;

	localparam int POS_BITS = 40;
	localparam int RATE_BITS = 48;
	localparam int OUT_BITS = 32;

	// multiplicand is split in two halves, each run through one shared multiplier
	localparam int HALF_BITS = RATE_BITS / 2;
	localparam int PROD_BITS = HALF_BITS + GAIN_BITS + 2;
	localparam int ACC_BITS = PROD_BITS + HALF_BITS;
	localparam int SUM_BITS = ACC_BITS + 1;

	localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(33554);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ALPHA = 2'd0,
		REG_VEL_GAIN = 2'd1,
		REG_STEP = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED_LO,
		ST_PRED_HI,
		ST_PRED_ACC,
		ST_PRED_UPD,
		ST_RESID,
		ST_ALPHA_LO,
		ST_ALPHA_HI,
		ST_ALPHA_ACC,
		ST_ALPHA_UPD,
		ST_VEL_LO,
		ST_VEL_HI,
		ST_VEL_ACC,
		ST_VEL_UPD,
		ST_DONE
	} state_t;

	typedef logic signed [SUM_BITS-1:0] sum_t;

	function automatic logic signed [POS_BITS-1:0] sat_pos(input sum_t v);
		logic [SUM_BITS-POS_BITS:0] top;
		top = v[SUM_BITS-1:POS_BITS-1];
		if (&top || ~|top) begin
			sat_pos = v[POS_BITS-1:0];
		end else if (v[SUM_BITS-1]) begin
			sat_pos = {1'b1, {(POS_BITS-1){1'b0}}};
		end else begin
			sat_pos = {1'b0, {(POS_BITS-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [RATE_BITS-1:0] sat_rate(input sum_t v);
		logic [SUM_BITS-RATE_BITS:0] top;
		top = v[SUM_BITS-1:RATE_BITS-1];
		if (&top || ~|top) begin
			sat_rate = v[RATE_BITS-1:0];
		end else if (v[SUM_BITS-1]) begin
			sat_rate = {1'b1, {(RATE_BITS-1){1'b0}}};
		end else begin
			sat_rate = {1'b0, {(RATE_BITS-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [OUT_BITS-1:0] sat_out(input sum_t v);
		logic [SUM_BITS-OUT_BITS:0] top;
		top = v[SUM_BITS-1:OUT_BITS-1];
		if (&top || ~|top) begin
			sat_out = v[OUT_BITS-1:0];
		end else if (v[SUM_BITS-1]) begin
			sat_out = {1'b1, {(OUT_BITS-1){1'b0}}};
		end else begin
			sat_out = {1'b0, {(OUT_BITS-1){1'b1}}};
		end
	endfunction

endpackage

FILE: rtl/alpha_beta_tracking_filter_unit.sv
// alpha-beta tracking filter, one signed sample in, one Q16.16 estimate out
// input word: sample and start_req on in_valid/in_ready; start_req clears the
// position and velocity state before the sample is used
// output word: estimate_out on out_valid/out_ready, held until taken
// gains and time step are written through cfg_wr_en/cfg_index/cfg_wdata; the
// user must write them only while idle, the block itself does not enforce it
// one shared 25x33 multiplier does all three gain products, each as two
// partial products (low and high half of the 48-bit operand) plus an
// accumulate and an update step, under a 15-state sequencer
// the estimate is registered in the done step; in_ready is high only when idle
// the output register frees the input side: a new word is taken while the
// previous estimate still waits; if the receiver stalls longer, the sequencer
// holds in its last step until the output register is free
// reset: state and velocity cleared, gains 0, time step 33554 (about 0.002),
// no output word pending
module alpha_beta_tracking_filter_unit
	import abtf_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_BITS-1:0]    sample,
	input  logic                             start_req,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [OUT_BITS-1:0]       estimate_out,
	input  logic                             cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]         cfg_wdata
);

	state_t state_q, state_d;

	logic [ALPHA_BITS-1:0] alpha_q;
	logic [GAIN_BITS-1:0] vel_gain_q;
	logic [STEP_BITS-1:0] step_q;

	logic signed [POS_BITS-1:0] pos_q;
	logic signed [RATE_BITS-1:0] rate_q;
	logic signed [RATE_BITS-1:0] resid_q;
	logic signed [MEAS_BITS-1:0] meas_q;
	logic signed [PROD_BITS-1:0] product_q;
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [OUT_BITS-1:0] estimate_q;
	logic out_valid_q;

	logic accept;
	logic done_go;
	logic is_pred;
	logic hi_phase;
	logic signed [RATE_BITS-1:0] mul_s;
	logic [GAIN_BITS-1:0] mul_u;
	logic signed [HALF_BITS:0] mul_a;
	logic signed [GAIN_BITS:0] mul_b;
	logic signed [PROD_BITS-1:0] mul_p;
	sum_t acc_shift;
	logic signed [POS_BITS-1:0] pos_next;
	logic signed [RATE_BITS-1:0] rate_next;
	logic signed [RATE_BITS-1:0] resid_next;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign estimate_out = estimate_q;
	assign done_go = !out_valid_q || out_ready;

	// shared multiplier: operand select and half select
	assign is_pred = (state_q == ST_PRED_LO) || (state_q == ST_PRED_HI) ||
		(state_q == ST_PRED_ACC) || (state_q == ST_PRED_UPD);
	assign hi_phase = (state_q == ST_PRED_HI) || (state_q == ST_ALPHA_HI) ||
		(state_q == ST_VEL_HI);
	assign mul_s = is_pred ? rate_q : resid_q;

	always_comb begin
		unique case (state_q)
			ST_PRED_LO, ST_PRED_HI: mul_u = GAIN_BITS'(step_q);
			ST_ALPHA_LO, ST_ALPHA_HI: mul_u = GAIN_BITS'(alpha_q);
			default: mul_u = vel_gain_q;
		endcase
	end

	assign mul_a = hi_phase ? {mul_s[RATE_BITS-1], mul_s[RATE_BITS-1:HALF_BITS]}
		: {1'b0, mul_s[HALF_BITS-1:0]};
	assign mul_b = {1'b0, mul_u};
	assign mul_p = mul_a * mul_b;

	// arithmetic shift gives the floor of the scaled product
	assign acc_shift = is_pred ? SUM_BITS'(acc_q >>> STEP_FRAC) : SUM_BITS'(acc_q >>> GAIN_FRAC);
	assign pos_next = sat_pos(acc_shift + SUM_BITS'(pos_q));
	assign rate_next = sat_rate(acc_shift + SUM_BITS'(rate_q));
	assign resid_next = sat_rate(SUM_BITS'(meas_q) - SUM_BITS'(pos_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_PRED_LO;
			ST_PRED_LO: state_d = ST_PRED_HI;
			ST_PRED_HI: state_d = ST_PRED_ACC;
			ST_PRED_ACC: state_d = ST_PRED_UPD;
			ST_PRED_UPD: state_d = ST_RESID;
			ST_RESID: state_d = ST_ALPHA_LO;
			ST_ALPHA_LO: state_d = ST_ALPHA_HI;
			ST_ALPHA_HI: state_d = ST_ALPHA_ACC;
			ST_ALPHA_ACC: state_d = ST_ALPHA_UPD;
			ST_ALPHA_UPD: state_d = ST_VEL_LO;
			ST_VEL_LO: state_d = ST_VEL_HI;
			ST_VEL_HI: state_d = ST_VEL_ACC;
			ST_VEL_ACC: state_d = ST_VEL_UPD;
			ST_VEL_UPD: state_d = ST_DONE;
			ST_DONE: if (done_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			vel_gain_q <= '0;
			step_q <= STEP_RESET;
			pos_q <= '0;
			rate_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_ALPHA: alpha_q <= cfg_wdata[ALPHA_BITS-1:0];
					REG_VEL_GAIN: vel_gain_q <= cfg_wdata[GAIN_BITS-1:0];
					REG_STEP: step_q <= cfg_wdata[STEP_BITS-1:0];
					default: ;
				endcase
			end
			if (accept && start_req) begin
				pos_q <= '0;
				rate_q <= '0;
			end
			if (state_q == ST_PRED_UPD || state_q == ST_ALPHA_UPD) begin
				pos_q <= pos_next;
			end
			if (state_q == ST_VEL_UPD) begin
				rate_q <= rate_next;
			end
			if (state_q == ST_DONE && done_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= {sample, {FRAC_BITS{1'b0}}};
		end
		if (state_q == ST_PRED_LO || state_q == ST_ALPHA_LO || state_q == ST_VEL_LO ||
			hi_phase) begin
			product_q <= mul_p;
		end
		if (hi_phase) begin
			// low partial product is never negative
			acc_q <= ACC_BITS'(product_q);
		end
		if (state_q == ST_PRED_ACC || state_q == ST_ALPHA_ACC || state_q == ST_VEL_ACC) begin
			acc_q <= acc_q + (ACC_BITS'(product_q) <<< HALF_BITS);
		end
		if (state_q == ST_RESID) begin
			resid_q <= resid_next;
		end
		if (state_q == ST_DONE && done_go) begin
			estimate_q <= sat_out(SUM_BITS'(pos_q));
		end
	end

endmodule

FILE: rtl/abtf_chk.sv
module abtf_chk
	import abtf_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [OUT_BITS-1:0] estimate_out
);

	// no word pending while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output word pending during reset");

	// sequencer stays busy after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken again while sequencer busy");

	// a new estimate appears only at the end of a busy period
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("estimate shown without work done");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(estimate_out))
		else $error("stalled output word changed");

endmodule

bind alpha_beta_tracking_filter_unit abtf_chk u_abtf_chk (.*);
